>>> rtl/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg
// Shared types and codes for the acquisition record deframer: word structs,
// layout, format and status codes, marker bytes, minimum record sizes.
// ----------------------------------------------------------------------------
package ard_pkg;

   // Input word: one record byte plus the final-byte flag
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_record;
   } ard_req_type;

   // Result word
   typedef struct packed {
      logic        result_kind;
      logic [63:0] sample_bits;
      logic [1:0]  sample_format;
      logic [15:0] channel_number;
      logic        channel_known;
      logic [47:0] timestamp_seconds;
      logic [2:0]  record_status;
      logic        last_result;
   } ard_rsp_type;

   // Up to two results produced by one input byte
   typedef struct packed {
      logic        sample_valid;
      logic        end_valid;
      ard_rsp_type sample_rsp;
      ard_rsp_type end_rsp;
   } ard_emit_type;

   // Result kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_END    = 1'b1;

   // Layout codes
   localparam logic [1:0] LAYOUT_NONE    = 2'd0;
   localparam logic [1:0] LAYOUT_DA      = 2'd1;
   localparam logic [1:0] LAYOUT_AB      = 2'd2;
   localparam logic [1:0] LAYOUT_UNKNOWN = 2'd3;

   // Sample format codes
   localparam logic [1:0] FMT_INT16   = 2'd0;
   localparam logic [1:0] FMT_INT32   = 2'd1;
   localparam logic [1:0] FMT_FLOAT32 = 2'd2;
   localparam logic [1:0] FMT_FLOAT64 = 2'd3;

   // Record status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
   localparam logic [2:0] ST_UNKNOWN     = 3'd2;
   localparam logic [2:0] ST_BAD_HEADER  = 3'd3;
   localparam logic [2:0] ST_BAD_MARKER  = 3'd4;
   localparam logic [2:0] ST_BAD_FORMAT  = 3'd5;
   localparam logic [2:0] ST_PAST_END    = 3'd6;

   // Marker bytes
   localparam logic [7:0] SYNC_DA   = 8'hDA;
   localparam logic [7:0] SYNC_AB   = 8'hAB;
   localparam logic [7:0] TAG_HDR   = 8'h01;
   localparam logic [7:0] TAG_DATA  = 8'h02;
   localparam logic [7:0] FMT_LIMIT = 8'h03;

   // Byte position counter saturates well above every header threshold
   localparam int POS_W = 6;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Minimum record sizes
   localparam logic [POS_W-1:0] MIN_DA      = 6'd12;
   localparam logic [POS_W-1:0] MIN_AB      = 6'd37;
   localparam logic [POS_W-1:0] MIN_UNKNOWN = 6'd2;

   // Result queue depth
   localparam int QUEUE_DEPTH = 4;

endpackage

>>> rtl/ard_parse.sv
// ----------------------------------------------------------------------------
// ard_parse
// Record state registers and the per-byte parse step: header checks, field
// collection, sample assembly and end-of-record status.
// ----------------------------------------------------------------------------
module ard_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ard_pkg::ard_req_type req,
   output ard_pkg::ard_emit_type emit
);
   import ard_pkg::*;

   // Header byte positions
   localparam logic [POS_W-1:0] P_TAG       = 6'd1;
   localparam logic [POS_W-1:0] DA_TS_LO    = 6'd6;
   localparam logic [POS_W-1:0] DA_TS_HI    = 6'd11;
   localparam logic [POS_W-1:0] DA_MARK0    = 6'd17;
   localparam logic [POS_W-1:0] DA_MARK1    = 6'd18;
   localparam logic [POS_W-1:0] DA_LEN_LO   = 6'd19;
   localparam logic [POS_W-1:0] DA_LEN_HI   = 6'd22;
   localparam logic [POS_W-1:0] DA_FMT      = 6'd23;
   localparam logic [POS_W-1:0] DA_DATA     = 6'd24;
   localparam logic [POS_W-1:0] AB_CH_LO    = 6'd6;
   localparam logic [POS_W-1:0] AB_CH_HI    = 6'd7;
   localparam logic [POS_W-1:0] AB_CH_DONE  = 6'd8;
   localparam logic [POS_W-1:0] AB_TS_LO    = 6'd10;
   localparam logic [POS_W-1:0] AB_TS_HI    = 6'd15;
   localparam logic [POS_W-1:0] AB_MARK0    = 6'd21;
   localparam logic [POS_W-1:0] AB_MARK1    = 6'd22;
   localparam logic [POS_W-1:0] AB_LEN_LO   = 6'd23;
   localparam logic [POS_W-1:0] AB_LEN_HI   = 6'd26;
   localparam logic [POS_W-1:0] AB_DATA     = 6'd27;

   // Sample byte index at which a sample is complete (wraps for 8 bytes)
   function automatic logic [2:0] sample_end_idx(input logic [1:0] fmt);
      logic [2:0] idx;
      case (fmt)
         FMT_INT16:   idx = 3'd2;
         FMT_FLOAT64: idx = 3'd0;
         default:     idx = 3'd4;
      endcase
      return idx;
   endfunction

   // Length rounded down to whole samples
   function automatic logic [31:0] align_len(input logic [31:0] len,
                                             input logic [1:0]  fmt);
      logic [31:0] res;
      case (fmt)
         FMT_INT16:   res = {len[31:1], 1'b0};
         FMT_FLOAT64: res = {len[31:3], 3'b000};
         default:     res = {len[31:2], 2'b00};
      endcase
      return res;
   endfunction

   // Sign-extend integers, pass floats as raw bits
   function automatic logic [63:0] sample_value(input logic [63:0] raw,
                                                input logic [1:0]  fmt);
      logic [63:0] res;
      case (fmt)
         FMT_INT16:   res = {{48{raw[15]}}, raw[15:0]};
         FMT_INT32:   res = {{32{raw[31]}}, raw[31:0]};
         FMT_FLOAT32: res = {32'd0, raw[31:0]};
         default:     res = raw;
      endcase
      return res;
   endfunction

   logic [POS_W-1:0] pos_ff,    pos_in,    n_pos;
   logic [1:0]       layout_ff, layout_in, n_layout;
   logic [31:0]      dlen_ff,   dlen_in,   n_dlen;
   logic [31:0]      dleft_ff,  dleft_in,  n_dleft;
   logic [47:0]      ts_ff,     ts_in,     n_ts;
   logic [15:0]      ch_ff,     ch_in,     n_ch;
   logic [63:0]      smp_ff,    smp_in,    n_smp;
   logic [2:0]       sidx_ff,   sidx_in,   n_sidx;
   logic [1:0]       fmt_ff,    fmt_in,    n_fmt;
   logic [2:0]       err_ff,    err_in,    n_err;

   logic [7:0]       b;
   logic             data_phase;
   logic [63:0]      shifted;
   logic             smp_emit;
   logic [63:0]      smp_val;
   logic             known;
   logic [POS_W-1:0] min_len;
   logic [2:0]       status;

   assign b = req.data_byte;

   // Parse step
   always_comb begin
      n_pos      = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 6'd1;
      n_layout   = layout_ff;
      n_dlen     = dlen_ff;
      n_dleft    = dleft_ff;
      n_ts       = ts_ff;
      n_ch       = ch_ff;
      n_smp      = smp_ff;
      n_sidx     = sidx_ff;
      n_fmt      = fmt_ff;
      n_err      = err_ff;
      data_phase = 1'b0;
      shifted    = {smp_ff[55:0], b};
      smp_emit   = 1'b0;
      smp_val    = '0;

      // header
      if (pos_ff == '0) begin
         if (b == SYNC_DA) begin
            n_layout = LAYOUT_DA;
         end else if (b == SYNC_AB) begin
            n_layout = LAYOUT_AB;
         end else begin
            n_layout = LAYOUT_UNKNOWN;
            n_err    = ST_UNKNOWN;
         end
      end else if (err_ff == ST_OK && layout_ff == LAYOUT_DA) begin
         if (pos_ff == P_TAG) begin
            if (b != TAG_HDR) n_err = ST_BAD_HEADER;
         end else if (pos_ff >= DA_TS_LO && pos_ff <= DA_TS_HI) begin
            n_ts = {ts_ff[39:0], b};
         end else if (pos_ff == DA_MARK0) begin
            if (b != SYNC_DA) n_err = ST_BAD_MARKER;
         end else if (pos_ff == DA_MARK1) begin
            if (b != TAG_DATA) n_err = ST_BAD_MARKER;
         end else if (pos_ff >= DA_LEN_LO && pos_ff <= DA_LEN_HI) begin
            n_dlen = {dlen_ff[23:0], b};
         end else if (pos_ff == DA_FMT) begin
            if (b > FMT_LIMIT) begin
               n_err = ST_BAD_FORMAT;
            end else begin
               n_fmt   = b[1:0];
               n_dleft = align_len(dlen_ff, b[1:0]);
            end
         end else if (pos_ff >= DA_DATA) begin
            data_phase = 1'b1;
         end
      end else if (err_ff == ST_OK && layout_ff == LAYOUT_AB) begin
         if (pos_ff == P_TAG) begin
            if (b != TAG_HDR) n_err = ST_BAD_HEADER;
         end else if (pos_ff == AB_CH_LO || pos_ff == AB_CH_HI) begin
            n_ch = {ch_ff[7:0], b};
         end else if (pos_ff >= AB_TS_LO && pos_ff <= AB_TS_HI) begin
            n_ts = {ts_ff[39:0], b};
         end else if (pos_ff == AB_MARK0) begin
            if (b != SYNC_AB) n_err = ST_BAD_MARKER;
         end else if (pos_ff == AB_MARK1) begin
            if (b != TAG_DATA) n_err = ST_BAD_MARKER;
         end else if (pos_ff >= AB_LEN_LO && pos_ff <= AB_LEN_HI) begin
            n_dlen = {dlen_ff[23:0], b};
            if (pos_ff == AB_LEN_HI) begin
               n_dleft = {dlen_ff[23:0], b};
               n_fmt   = FMT_INT16;
            end
         end else if (pos_ff >= AB_DATA) begin
            data_phase = 1'b1;
         end
      end

      // sample assembly
      if (data_phase && dleft_ff != '0) begin
         n_dleft = dleft_ff - 32'd1;
         n_sidx  = sidx_ff + 3'd1;
         n_smp   = shifted;
         if (n_sidx == sample_end_idx(fmt_ff)) begin
            smp_emit = 1'b1;
            smp_val  = sample_value(shifted, fmt_ff);
            n_smp    = '0;
            n_sidx   = '0;
         end
      end
   end

   // End-of-record status
   always_comb begin
      case (n_layout)
         LAYOUT_DA: min_len = MIN_DA;
         LAYOUT_AB: min_len = MIN_AB;
         default:   min_len = MIN_UNKNOWN;
      endcase
      if (n_pos < min_len) begin
         status = ST_TOO_SMALL;
      end else if (n_err != ST_OK) begin
         status = n_err;
      end else if (n_layout == LAYOUT_DA && n_pos <= DA_MARK1) begin
         status = ST_BAD_MARKER;
      end else if (n_layout == LAYOUT_DA && n_pos <= DA_FMT) begin
         status = ST_PAST_END;
      end else if (n_dleft != '0) begin
         status = ST_PAST_END;
      end else begin
         status = ST_OK;
      end
   end

   // Result words
   assign known = (n_layout == LAYOUT_AB) && (n_pos >= AB_CH_DONE) &&
                  (n_err != ST_BAD_HEADER);

   always_comb begin
      emit.sample_valid                 = fire && smp_emit;
      emit.end_valid                    = fire && req.end_of_record;

      emit.sample_rsp.result_kind       = KIND_SAMPLE;
      emit.sample_rsp.sample_bits       = smp_val;
      emit.sample_rsp.sample_format     = fmt_ff;
      emit.sample_rsp.channel_number    = known ? n_ch : 16'd0;
      emit.sample_rsp.channel_known     = known;
      emit.sample_rsp.timestamp_seconds = n_ts;
      emit.sample_rsp.record_status     = ST_OK;
      emit.sample_rsp.last_result       = !req.end_of_record;

      emit.end_rsp.result_kind          = KIND_END;
      emit.end_rsp.sample_bits          = '0;
      emit.end_rsp.sample_format        = FMT_INT16;
      emit.end_rsp.channel_number       = known ? n_ch : 16'd0;
      emit.end_rsp.channel_known        = known;
      emit.end_rsp.timestamp_seconds    = n_ts;
      emit.end_rsp.record_status        = status;
      emit.end_rsp.last_result          = 1'b1;
   end

   // Next state: hold when idle, clear after the final byte
   always_comb begin
      pos_in    = pos_ff;
      layout_in = layout_ff;
      dlen_in   = dlen_ff;
      dleft_in  = dleft_ff;
      ts_in     = ts_ff;
      ch_in     = ch_ff;
      smp_in    = smp_ff;
      sidx_in   = sidx_ff;
      fmt_in    = fmt_ff;
      err_in    = err_ff;
      if (fire) begin
         if (req.end_of_record) begin
            pos_in    = '0;
            layout_in = LAYOUT_NONE;
            dlen_in   = '0;
            dleft_in  = '0;
            ts_in     = '0;
            ch_in     = '0;
            smp_in    = '0;
            sidx_in   = '0;
            fmt_in    = FMT_INT16;
            err_in    = ST_OK;
         end else begin
            pos_in    = n_pos;
            layout_in = n_layout;
            dlen_in   = n_dlen;
            dleft_in  = n_dleft;
            ts_in     = n_ts;
            ch_in     = n_ch;
            smp_in    = n_smp;
            sidx_in   = n_sidx;
            fmt_in    = n_fmt;
            err_in    = n_err;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         layout_ff <= LAYOUT_NONE;
         dlen_ff   <= '0;
         dleft_ff  <= '0;
         ts_ff     <= '0;
         ch_ff     <= '0;
         smp_ff    <= '0;
         sidx_ff   <= '0;
         fmt_ff    <= FMT_INT16;
         err_ff    <= ST_OK;
      end else begin
         pos_ff    <= pos_in;
         layout_ff <= layout_in;
         dlen_ff   <= dlen_in;
         dleft_ff  <= dleft_in;
         ts_ff     <= ts_in;
         ch_ff     <= ch_in;
         smp_ff    <= smp_in;
         sidx_ff   <= sidx_in;
         fmt_ff    <= fmt_in;
         err_ff    <= err_in;
      end
   end

endmodule

>>> rtl/ard_queue.sv
// ----------------------------------------------------------------------------
// ard_queue
// Small result queue: takes up to two result words per cycle, hands one word
// per cycle to the result channel while rsp_stall is low, and stalls the
// input while fewer than two slots are free.
// ----------------------------------------------------------------------------
module ard_queue #(
   parameter int DEPTH = ard_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ard_pkg::ard_emit_type emit,
   output logic                  full2,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ard_pkg::ard_rsp_type  rsp_data
);
   import ard_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

   ard_rsp_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;
   logic [1:0]       push_n;
   logic [PTR_W-1:0] end_slot;

   // Pointer advance, wraps at the queue depth
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                input logic [1:0]       step);
      logic [PTR_W:0] sum;
      sum = {1'b0, ptr} + (PTR_W+1)'(step);
      if (sum >= (PTR_W+1)'(DEPTH)) sum = sum - (PTR_W+1)'(DEPTH);
      return sum[PTR_W-1:0];
   endfunction

   assign pop       = rsp_valid && !rsp_stall;
   assign push_n    = {1'b0, emit.sample_valid} + {1'b0, emit.end_valid};
   assign end_slot  = emit.sample_valid ? ptr_add(wr_ff, 2'd1) : wr_ff;
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = slot_ff[rd_ff];
   assign full2     = cnt_ff > ROOM_LIMIT;

   // Pointer and count update
   always_comb begin
      wr_in  = ptr_add(wr_ff, push_n);
      rd_in  = pop ? ptr_add(rd_ff, 2'd1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (emit.sample_valid) slot_ff[wr_ff] <= emit.sample_rsp;
      if (emit.end_valid)    slot_ff[end_slot] <= emit.end_rsp;
   end

endmodule

>>> rtl/acquisition_record_deframer.sv
// ----------------------------------------------------------------------------
// acquisition_record_deframer
// Splits one acquisition record byte stream into sample words and an
// end-of-record status word.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one record byte per word, end_of_record set on the
//   final byte. The first byte picks layout 0xDA or 0xAB; markers are checked
//   and timestamp, channel and data length are collected from the header.
//   rsp_ channel returns one word per whole sample (kind 0) and, for the
//   final byte, an end word (kind 1) with the record status; last_result
//   flags the last word caused by each byte.
//   A byte's first result is on rsp_ the cycle after it is accepted when the
//   queue is empty; words already queued ahead of it are handed out first.
//   Throughput: one byte per cycle while req_stall is low. The parse step is a
//   single pass between the record state registers and a 4-entry result
//   queue; the queue drains one word per cycle while rsp_stall is low, so a
//   byte that yields two words (final sample plus end word) leaves one extra
//   word queued. req_stall rises while the queue has fewer than two free
//   entries, so a stalled rsp_ side backs up into req_ without losing words.
//   Reset clears the record state and empties the queue; state also returns
//   to its reset values after every final byte.
// ----------------------------------------------------------------------------
module acquisition_record_deframer #(
   parameter int QueueDepth = ard_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ard_pkg::ard_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ard_pkg::ard_rsp_type rsp_data
);
   import ard_pkg::*;

   logic         fire;
   logic         full2;
   ard_emit_type emit;

   assign req_stall = full2;
   assign fire      = req_valid && !req_stall;

   // Parse step and record state
   ard_parse u_parse (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_data),
      .emit  (emit)
   );

   // Result queue
   ard_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .full2     (full2),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Assertions
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result queue");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_END |-> rsp_data.last_result)
      else $error("end word without last_result");

   a_sample_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_SAMPLE
      |-> rsp_data.record_status == ST_OK)
      else $error("sample word carries a status");

   a_end_follows: assert property (@(posedge clock) disable iff (reset)
      fire && req_data.end_of_record |=> rsp_valid)
      else $error("no result after final byte");

endmodule
